[rtl/status_led_priority_pattern_defines.svh]
// Assertion macros shared by the status LED pattern block.
`ifndef STATUS_LED_PRIORITY_PATTERN_DEFINES_SVH
`define STATUS_LED_PRIORITY_PATTERN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLPP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/slpp_pkg.sv]
package slpp_pkg;

  localparam int TICK_BITS = 32;

  localparam int CMD_BITS   = 3;
  localparam int LVL_BITS   = 8;
  localparam int CFG_IDX_BITS = 1;
  localparam int PHASE_BITS = 5;

  localparam logic [CMD_BITS-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_ACTIVITY = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_LINES    = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_FLASH    = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_ERROR    = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHTNESS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS = 1'd1;

  localparam logic [LVL_BITS-1:0] BRIGHTNESS_RESET = 8'd24;
  localparam logic [LVL_BITS-1:0] HOLD_TICKS_RESET = 8'd2;

  localparam logic [PHASE_BITS-1:0] PULSE_PERIOD = 5'd20;
  localparam logic [PHASE_BITS-1:0] PULSE_ON     = 5'd6;
  localparam logic [PHASE_BITS-1:0] BLINK_HALF   = 5'd5;
  localparam logic [PHASE_BITS-1:0] BLINK_PERIOD = 5'd10;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [LVL_BITS-1:0]  lvl_t;

  // Two fifths of the level, truncated: (2 * lvl * 205) >> 10 is exact for lvl below 256.
  function automatic lvl_t amber_green(input lvl_t lvl);
    logic [18:0] prod;
    prod = {10'd0, lvl, 1'b0} * 19'd205;
    return prod[17:10];
  endfunction

endpackage

[rtl/status_led_priority_pattern.sv]
// Status RGB LED pattern controller.
// Input channel: in_valid/in_stall carry one event word per accepted cycle
// (tick, activity, target line levels, flashing mode or error).
// Output channel: out_valid/out_stall carry a new colour word, produced only
// by a tick whose chosen colour differs from the last colour sent.
// Configuration: cfg_valid/cfg_ready write brightness (index 0) or the
// activity hold time in ticks (index 1); cfg_ready is always high.
// An event word is registered on acceptance and processed from the input
// register once the output register is free; its colour word is registered there.
// Throughput: one event word per cycle while the receiver does not stall, set by
// the single update stage between the input register and the output register.
// When the receiver stalls, the colour word holds; the input register still
// accepts one more word, and in_stall rises only when both registers are full.
// Reset clears the tick count, pulse phase, deadlines, line levels, flashing mode,
// the sticky error, both valid flags and the last colour, which starts at black,
// and restores brightness 24 and hold time 2; event data and colour registers are not reset.
`include "status_led_priority_pattern_defines.svh"

module status_led_priority_pattern (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [slpp_pkg::CMD_BITS-1:0]     in_cmd,
  input  logic                              in_is_debug_channel,
  input  logic                              in_active,
  input  logic                              in_boot_level,
  input  logic                              in_reset_level,
  input  logic                              in_flashing_on,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [slpp_pkg::LVL_BITS-1:0]     out_red,
  output logic [slpp_pkg::LVL_BITS-1:0]     out_green,
  output logic [slpp_pkg::LVL_BITS-1:0]     out_blue,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slpp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [slpp_pkg::LVL_BITS-1:0]     cfg_data
);

  logic                              in_valid_r;
  logic [slpp_pkg::CMD_BITS-1:0]     cmd_r;
  logic                              dbg_r, act_r, boot_r, rst_r, flash_r;

  slpp_pkg::lvl_t                    brightness_r, hold_ticks_r;
  slpp_pkg::tick_t                   tick_count_r, tick_count_nxt;
  slpp_pkg::tick_t                   serial_dl_r, serial_dl_nxt;
  slpp_pkg::tick_t                   debug_dl_r, debug_dl_nxt;
  logic [slpp_pkg::PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic                              boot_low_r, boot_low_nxt;
  logic                              reset_low_r, reset_low_nxt;
  logic                              flash_mode_r, flash_mode_nxt;
  logic                              error_r, error_nxt;
  logic [23:0]                       last_colour_r, last_colour_nxt;

  logic                              out_valid_r, out_valid_nxt;
  slpp_pkg::lvl_t                    red_r, green_r, blue_r;
  slpp_pkg::lvl_t                    red_c, green_c, blue_c;

  logic                              adv, work, half, pulse, emit;
  slpp_pkg::tick_t                   dl_new, dbg_diff, ser_diff;
  logic                              dbg_live, ser_live;

  assign adv       = !out_valid_r || !out_stall;
  assign work      = in_valid_r && adv;
  assign in_stall  = in_valid_r && !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  always_comb begin
    tick_count_nxt  = tick_count_r;
    phase_nxt       = phase_r;
    serial_dl_nxt   = serial_dl_r;
    debug_dl_nxt    = debug_dl_r;
    boot_low_nxt    = boot_low_r;
    reset_low_nxt   = reset_low_r;
    flash_mode_nxt  = flash_mode_r;
    error_nxt       = error_r;
    last_colour_nxt = last_colour_r;
    out_valid_nxt   = adv ? 1'b0 : out_valid_r;
    red_c           = '0;
    green_c         = '0;
    blue_c          = '0;
    emit            = 1'b0;
    dl_new          = tick_count_r + slpp_pkg::tick_t'(hold_ticks_r);

    // The tick count wraps to zero, where the pulse phase restarts too.
    tick_count_nxt = tick_count_r + 1'b1;
    if (tick_count_r == '1 || phase_r == slpp_pkg::PULSE_PERIOD - 1'b1) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_r + 1'b1;
    end
    half  = (phase_nxt < slpp_pkg::BLINK_HALF) ||
            ((phase_nxt >= slpp_pkg::BLINK_PERIOD) &&
             (phase_nxt < slpp_pkg::BLINK_PERIOD + slpp_pkg::BLINK_HALF));
    pulse = phase_nxt < slpp_pkg::PULSE_ON;

    dbg_diff = debug_dl_r - tick_count_nxt;
    ser_diff = serial_dl_r - tick_count_nxt;
    dbg_live = (dbg_diff != '0) && !dbg_diff[slpp_pkg::TICK_BITS-1];
    ser_live = (ser_diff != '0) && !ser_diff[slpp_pkg::TICK_BITS-1];

    if (error_r) begin
      red_c = tick_count_nxt[0] ? brightness_r : '0;
    end else if (reset_low_r) begin
      red_c = pulse ? brightness_r : '0;
    end else if (boot_low_r) begin
      red_c   = brightness_r;
      green_c = slpp_pkg::amber_green(brightness_r);
    end else if (flash_mode_r) begin
      red_c  = half ? brightness_r : '0;
      blue_c = half ? brightness_r : '0;
    end else if (dbg_live) begin
      blue_c = brightness_r;
    end else if (ser_live) begin
      green_c = brightness_r;
    end

    if (!work) begin
      tick_count_nxt = tick_count_r;
      phase_nxt      = phase_r;
    end else begin
      unique case (cmd_r)
        slpp_pkg::CMD_TICK: begin
          emit = {red_c, green_c, blue_c} != last_colour_r;
          if (emit) begin
            last_colour_nxt = {red_c, green_c, blue_c};
            out_valid_nxt   = 1'b1;
          end
        end
        slpp_pkg::CMD_ACTIVITY: begin
          if (act_r) begin
            if (dbg_r) begin
              debug_dl_nxt = dl_new;
            end else begin
              serial_dl_nxt = dl_new;
            end
          end
        end
        slpp_pkg::CMD_LINES: begin
          boot_low_nxt  = !boot_r;
          reset_low_nxt = !rst_r;
        end
        slpp_pkg::CMD_FLASH: begin
          flash_mode_nxt = flash_r;
        end
        slpp_pkg::CMD_ERROR: begin
          error_nxt = 1'b1;
        end
        default: begin
        end
      endcase
      if (cmd_r != slpp_pkg::CMD_TICK) begin
        tick_count_nxt = tick_count_r;
        phase_nxt      = phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      brightness_r  <= slpp_pkg::BRIGHTNESS_RESET;
      hold_ticks_r  <= slpp_pkg::HOLD_TICKS_RESET;
      tick_count_r  <= '0;
      phase_r       <= '0;
      serial_dl_r   <= '0;
      debug_dl_r    <= '0;
      boot_low_r    <= 1'b0;
      reset_low_r   <= 1'b0;
      flash_mode_r  <= 1'b0;
      error_r       <= 1'b0;
      last_colour_r <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      out_valid_r   <= out_valid_nxt;
      tick_count_r  <= tick_count_nxt;
      phase_r       <= phase_nxt;
      serial_dl_r   <= serial_dl_nxt;
      debug_dl_r    <= debug_dl_nxt;
      boot_low_r    <= boot_low_nxt;
      reset_low_r   <= reset_low_nxt;
      flash_mode_r  <= flash_mode_nxt;
      error_r       <= error_nxt;
      last_colour_r <= last_colour_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          slpp_pkg::REG_BRIGHTNESS: brightness_r <= cfg_data;
          slpp_pkg::REG_HOLD_TICKS: hold_ticks_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      cmd_r   <= in_cmd;
      dbg_r   <= in_is_debug_channel;
      act_r   <= in_active;
      boot_r  <= in_boot_level;
      rst_r   <= in_reset_level;
      flash_r <= in_flashing_on;
    end
    if (work && emit) begin
      red_r   <= red_c;
      green_r <= green_c;
      blue_r  <= blue_c;
    end
  end

  `SLPP_ASSERT_SAME(a_out_matches_last, clk, rst_n, out_valid_r, {red_r, green_r, blue_r} == last_colour_r, "pending colour differs from last colour")
  `SLPP_ASSERT_SAME(a_stall_only_full, clk, rst_n, in_stall, in_valid_r && out_valid_r && out_stall, "input stalled while a register is free")
  `SLPP_ASSERT_NEXT(a_error_sticky, clk, rst_n, error_r, error_r, "error cleared without reset")
  `SLPP_ASSERT_SAME(a_phase_range, clk, rst_n, 1'b1, phase_r < slpp_pkg::PULSE_PERIOD, "pulse phase out of range")

endmodule

[sim/tb_status_led_priority_pattern.sv]
`timescale 1ns / 100ps

module tb_status_led_priority_pattern;
  import slpp_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_C = 3'd7;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    lvl_t red;
    lvl_t green;
    lvl_t blue;
  } colour_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_BITS-1:0] in_cmd;
  logic in_is_debug_channel;
  logic in_active;
  logic in_boot_level;
  logic in_reset_level;
  logic in_flashing_on;
  logic out_valid;
  logic out_stall;
  lvl_t out_red;
  lvl_t out_green;
  lvl_t out_blue;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  lvl_t cfg_data;

  lvl_t bright_lvl = BRIGHTNESS_RESET;
  lvl_t hold_span = HOLD_TICKS_RESET;
  tick_t tick_now = '0;
  tick_t serial_due = '0;
  tick_t debug_due = '0;
  bit boot_low = 1'b0;
  bit reset_low = 1'b0;
  bit flash_mode = 1'b0;
  bit err_latched = 1'b0;
  colour_t shown_colour = '0;
  colour_t colour_expected[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit calm = 1'b0;

  logic [CMD_BITS-1:0] spare_cmds[3] = '{CMD_SPARE_A, CMD_SPARE_B, CMD_SPARE_C};

  status_led_priority_pattern dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_is_debug_channel(in_is_debug_channel),
    .in_active(in_active),
    .in_boot_level(in_boot_level),
    .in_reset_level(in_reset_level),
    .in_flashing_on(in_flashing_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit deadline_ahead(input tick_t due, input tick_t now);
    tick_t diff;
    diff = due - now;
    return diff != '0 && !diff[TICK_BITS-1];
  endfunction

  task automatic apply_event(input logic [CMD_BITS-1:0] cmd, input logic dbg, input logic act,
                             input logic boot, input logic rstl, input logic flash);
    colour_t next;
    bit half;
    next = '0;
    case (cmd)
      CMD_ACTIVITY: begin
        if (act) begin
          if (dbg) debug_due = tick_now + tick_t'(hold_span);
          else serial_due = tick_now + tick_t'(hold_span);
        end
      end
      CMD_LINES: begin
        boot_low = !boot;
        reset_low = !rstl;
      end
      CMD_FLASH: flash_mode = flash;
      CMD_ERROR: err_latched = 1'b1;
      CMD_TICK: begin
        tick_now = tick_now + 1'b1;
        half = (tick_now % BLINK_PERIOD) < BLINK_HALF;
        if (err_latched) begin
          next.red = tick_now[0] ? bright_lvl : '0;
        end else if (reset_low) begin
          next.red = (tick_now % PULSE_PERIOD) < PULSE_ON ? bright_lvl : '0;
        end else if (boot_low) begin
          next.red = bright_lvl;
          next.green = lvl_t'((32'(bright_lvl) * 2) / 5);
        end else if (flash_mode) begin
          next.red = half ? bright_lvl : '0;
          next.blue = half ? bright_lvl : '0;
        end else if (deadline_ahead(debug_due, tick_now)) begin
          next.blue = bright_lvl;
        end else if (deadline_ahead(serial_due, tick_now)) begin
          next.green = bright_lvl;
        end
        if (next != shown_colour) begin
          shown_colour = next;
          colour_expected.push_back(next);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Scoreboard, configuration mirror and watchdog share one sampling point.
  always @(posedge clk) begin
    colour_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (colour_expected.size() == 0) begin
          $error("unexpected colour word: red %0d green %0d blue %0d",
                 out_red, out_green, out_blue);
          fail_count++;
        end else begin
          want = colour_expected.pop_front();
          if (out_red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_red);
            fail_count++;
          end
          if (out_green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_green);
            fail_count++;
          end
          if (out_blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_blue);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        apply_event(in_cmd, in_is_debug_channel, in_active, in_boot_level,
                    in_reset_level, in_flashing_on);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_BRIGHTNESS: bright_lvl = cfg_data;
          REG_HOLD_TICKS: hold_span = cfg_data;
          default: begin
          end
        endcase
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(0, 99) < 25;
    end
  end

  task automatic send_event(input logic [CMD_BITS-1:0] cmd, input logic dbg, input logic act,
                            input logic boot, input logic rstl, input logic flash);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_is_debug_channel <= dbg;
    in_active <= act;
    in_boot_level <= boot;
    in_reset_level <= rstl;
    in_flashing_on <= flash;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_event();
    int pick;
    logic [CMD_BITS-1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 50) cmd = CMD_TICK;
    else if (pick < 70) cmd = CMD_ACTIVITY;
    else if (pick < 82) cmd = CMD_LINES;
    else if (pick < 92) cmd = CMD_FLASH;
    else cmd = spare_cmds[$urandom_range(0, 2)];
    send_event(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
               $urandom_range(0, 2) == 0);
  endtask

  task automatic wait_settled();
    in_valid <= 1'b0;
    while (colour_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_levels(input lvl_t brightness, input lvl_t hold);
    wait_settled();
    cfg_valid <= 1'b1;
    cfg_index <= REG_BRIGHTNESS;
    cfg_data <= brightness;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_HOLD_TICKS;
    cfg_data <= hold;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_power_up();
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_each_event();
    send_event(CMD_ACTIVITY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_event(CMD_ACTIVITY, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_event(CMD_ACTIVITY, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(CMD_ACTIVITY, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_FLASH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_LINES, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_LINES, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_SPARE_A, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_event(CMD_SPARE_B, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_event(CMD_SPARE_C, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_event(CMD_LINES, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_event(CMD_FLASH, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_event();
  endtask

  task automatic test_backpressure();
    send_event(CMD_LINES, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    calm = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_event(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
    calm = 1'b0;
    send_event(CMD_LINES, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_sticky_error();
    send_event(CMD_ERROR, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    repeat (10) send_event(CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    test_random_mix(80);
    set_levels(8'd1, 8'd255);
    send_event(CMD_ERROR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    test_random_mix(40);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_TICK;
    in_is_debug_channel = 1'b0;
    in_active = 1'b0;
    in_boot_level = 1'b1;
    in_reset_level = 1'b1;
    in_flashing_on = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_BRIGHTNESS;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up();
    test_each_event();
    test_random_mix(260);
    set_levels(8'd255, 8'd255);
    test_random_mix(260);
    set_levels(8'd0, 8'd0);
    calm = 1'b1;
    test_random_mix(150);
    calm = 1'b0;
    set_levels(lvl_t'($urandom_range(1, 254)), lvl_t'($urandom_range(0, 8)));
    test_random_mix(260);
    test_backpressure();
    set_levels(8'd255, 8'd0);
    test_sticky_error();
    wait_settled();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
